// ===== hdl/mfd_pkg.sv =====
// Package for the market feed message decoder: kinds, byte codes and the
// per-kind payload layout functions. No dependencies.
`timescale 1ns / 1ps
package mfd_pkg;

  localparam logic [3:0] KIND_A    = 4'd0;
  localparam logic [3:0] KIND_F    = 4'd1;
  localparam logic [3:0] KIND_E    = 4'd2;
  localparam logic [3:0] KIND_C    = 4'd3;
  localparam logic [3:0] KIND_X    = 4'd4;
  localparam logic [3:0] KIND_D    = 4'd5;
  localparam logic [3:0] KIND_U    = 4'd6;
  localparam logic [3:0] KIND_T    = 4'd7;
  localparam logic [3:0] KIND_SKIP = 4'd8;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_F = 8'h46;
  localparam logic [7:0] CHAR_E = 8'h45;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_X = 8'h58;
  localparam logic [7:0] CHAR_D = 8'h44;
  localparam logic [7:0] CHAR_U = 8'h55;
  localparam logic [7:0] CHAR_T = 8'h54;

  localparam logic [2:0] SLOT_TIME   = 3'd0;
  localparam logic [2:0] SLOT_ORDER  = 3'd1;
  localparam logic [2:0] SLOT_VOLUME = 3'd2;
  localparam logic [2:0] SLOT_SYMBOL = 3'd3;
  localparam logic [2:0] SLOT_PRICE  = 3'd4;
  localparam logic [2:0] SLOT_SECOND = 3'd5;

  typedef enum logic [1:0] {
    POS_LEAD,
    POS_LENGTH,
    POS_TYPE,
    POS_PAYLOAD
  } pos_t;

  // One classified byte handed from the front part to the back part.
  typedef struct packed {
    logic       start;  // type byte: clear the assembly fields
    logic       write;  // payload byte of a known kind
    logic [2:0] slot;
    logic       sym;    // byte belongs to the symbol field
    logic       last;   // final payload byte
    logic [3:0] kind;
    logic [7:0] data;
  } beat_t;

  function automatic logic [3:0] decode_type(input logic [7:0] b);
    logic [3:0] k;
    unique case (b)
      CHAR_A:  k = KIND_A;
      CHAR_F:  k = KIND_F;
      CHAR_E:  k = KIND_E;
      CHAR_C:  k = KIND_C;
      CHAR_X:  k = KIND_X;
      CHAR_D:  k = KIND_D;
      CHAR_U:  k = KIND_U;
      CHAR_T:  k = KIND_T;
      default: k = KIND_SKIP;
    endcase
    return k;
  endfunction

  // Total payload length of each known kind.
  function automatic logic [5:0] payload_len(input logic [3:0] kind);
    logic [5:0] n;
    unique case (kind)
      KIND_A:  n = 6'd29;
      KIND_F:  n = 6'd33;
      KIND_E:  n = 6'd24;
      KIND_C:  n = 6'd29;
      KIND_X:  n = 6'd16;
      KIND_D:  n = 6'd12;
      KIND_U:  n = 6'd28;
      default: n = 6'd4;
    endcase
    return n;
  endfunction

  // Slot that a payload offset lands in; offsets past the end read slot 0.
  function automatic logic [2:0] locate(input logic [3:0] kind, input logic [7:0] off);
    logic [2:0] s;
    s = SLOT_TIME;
    if (off >= 8'd4 && off < 8'd12) s = SLOT_ORDER;
    unique case (kind)
      KIND_A, KIND_F: begin
        if (off >= 8'd13 && off < 8'd17) s = SLOT_VOLUME;
        else if (off >= 8'd17 && off < 8'd25) s = SLOT_SYMBOL;
        else if (off >= 8'd25 && off < 8'd29) s = SLOT_PRICE;
        else if (kind == KIND_F && off >= 8'd29 && off < 8'd33) s = SLOT_SECOND;
      end
      KIND_E, KIND_C: begin
        if (off >= 8'd12 && off < 8'd16) s = SLOT_VOLUME;
        else if (off >= 8'd16 && off < 8'd24) s = SLOT_SECOND;
        else if (kind == KIND_C && off >= 8'd25 && off < 8'd29) s = SLOT_PRICE;
      end
      KIND_X: begin
        if (off >= 8'd12 && off < 8'd16) s = SLOT_VOLUME;
      end
      KIND_U: begin
        if (off >= 8'd12 && off < 8'd20) s = SLOT_SECOND;
        else if (off >= 8'd20 && off < 8'd24) s = SLOT_VOLUME;
        else if (off >= 8'd24 && off < 8'd28) s = SLOT_PRICE;
      end
      default: begin
        if (kind == KIND_T || kind == KIND_D) s = (kind == KIND_T) ? SLOT_TIME : s;
      end
    endcase
    if (kind == KIND_T) s = SLOT_TIME;
    return s;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

endpackage

// ===== hdl/market_feed_message_decoder.sv =====
// Top level of the market feed message decoder: front classifier, beat queue
// and back assembler. Depends on mfd_pkg, mfd_front, mfd_queue and mfd_back.
`timescale 1ns / 1ps
// The decoder takes one stream byte per cycle (push/full) and delivers one
// decoded record (empty/pop) on the last payload byte of each A, F, E, C, X,
// D or U message; T messages update the stored seconds and unknown types are
// skipped by their length byte. The combinational front classifier writes
// each type byte and known payload byte as a beat into a four-beat queue at
// the edge that accepts it; the back assembler takes one beat per cycle from
// that queue while the two-record output buffer has room, writing each
// record there as it takes the last beat; throughput is one byte per cycle
// while pop keeps up. Queue and buffer absorb stalls; full rises once both fill.
module market_feed_message_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  stream_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  msg_kind,
  output logic [31:0] time_seconds,
  output logic [31:0] time_fraction,
  output logic [63:0] order_reference,
  output logic [7:0]  side_flag,
  output logic [31:0] share_count,
  output logic [63:0] symbol_bytes,
  output logic [31:0] price_raw,
  output logic [31:0] participant_id,
  output logic [63:0] second_reference,
  output logic [7:0]  printable_flag
);

  logic           fb_valid, q_full, q_valid, q_pop;
  mfd_pkg::beat_t fb_beat, q_beat;

  mfd_front u_front (
    .clk, .rst, .push, .stream_byte, .full,
    .beat_valid(fb_valid), .beat(fb_beat), .beat_full(q_full)
  );

  mfd_queue u_queue (
    .clk, .rst, .wr(fb_valid), .wr_beat(fb_beat), .full(q_full),
    .rd_valid(q_valid), .rd_beat(q_beat), .rd(q_pop)
  );

  mfd_back u_back (
    .clk, .rst, .beat_valid(q_valid), .beat(q_beat), .beat_pop(q_pop),
    .empty, .pop, .msg_kind, .time_seconds, .time_fraction, .order_reference,
    .side_flag, .share_count, .symbol_bytes, .price_raw, .participant_id,
    .second_reference, .printable_flag
  );

endmodule

// ===== hdl/mfd_front.sv =====
// Front part: tracks message framing, skips unknown types and classifies
// each payload byte into a slot. Depends on mfd_pkg.
`timescale 1ns / 1ps
module mfd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic [7:0]      stream_byte,
  output logic            full,
  output logic            beat_valid,
  output mfd_pkg::beat_t  beat,
  input  logic            beat_full
);

  mfd_pkg::pos_t pos, pos_next;
  logic [3:0]    kind, kind_next;
  logic [7:0]    skip, skip_next;
  logic [7:0]    off, off_next;
  logic          take;
  logic [3:0]    new_kind;

  assign full = beat_full;
  assign take = push && !beat_full;
  assign new_kind = mfd_pkg::decode_type(stream_byte);

  always_comb begin
    pos_next  = pos;
    kind_next = kind;
    skip_next = skip;
    off_next  = off;
    beat_valid = 1'b0;
    beat = '0;
    beat.data = stream_byte;
    beat.kind = kind;
    if (take) begin
      unique case (pos)
        mfd_pkg::POS_LEAD: pos_next = mfd_pkg::POS_LENGTH;
        mfd_pkg::POS_LENGTH: begin
          skip_next = stream_byte - 8'd1;
          pos_next  = mfd_pkg::POS_TYPE;
        end
        mfd_pkg::POS_TYPE: begin
          kind_next = new_kind;
          off_next  = 8'd0;
          beat_valid = 1'b1;
          beat.start = 1'b1;
          if (new_kind == mfd_pkg::KIND_SKIP && skip == 8'd0) pos_next = mfd_pkg::POS_LEAD;
          else pos_next = mfd_pkg::POS_PAYLOAD;
        end
        mfd_pkg::POS_PAYLOAD: begin
          if (kind >= mfd_pkg::KIND_SKIP) begin
            skip_next = skip - 8'd1;
            if (skip == 8'd1) pos_next = mfd_pkg::POS_LEAD;
          end else begin
            beat_valid = 1'b1;
            beat.write = 1'b1;
            beat.slot  = mfd_pkg::locate(kind, off);
            beat.sym   = (beat.slot == mfd_pkg::SLOT_SYMBOL);
            beat.last  = (off + 8'd1 >= {2'b00, mfd_pkg::payload_len(kind)});
            off_next   = off + 8'd1;
            if (beat.last) pos_next = mfd_pkg::POS_LEAD;
          end
        end
        default: pos_next = mfd_pkg::POS_LEAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= mfd_pkg::POS_LEAD;
      kind <= 4'd0;
      skip <= 8'd0;
      off  <= 8'd0;
    end else begin
      pos  <= pos_next;
      kind <= kind_next;
      skip <= skip_next;
      off  <= off_next;
    end
  end

endmodule

// ===== hdl/mfd_queue.sv =====
// Short queue of classified beats between the front and back parts.
// Depends on mfd_pkg.
`timescale 1ns / 1ps
module mfd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  mfd_pkg::beat_t wr_beat,
  output logic           full,
  output logic           rd_valid,
  output mfd_pkg::beat_t rd_beat,
  input  logic           rd
);

  mfd_pkg::beat_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] count;

  assign full     = (count == 3'd4);
  assign rd_valid = (count != 3'd0);
  assign rd_beat  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr && !full) mem[wp] <= wr_beat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 2'd0;
      rp <= 2'd0;
      count <= 3'd0;
    end else begin
      if (wr && !full) wp <= wp + 2'd1;
      if (rd && rd_valid) rp <= rp + 2'd1;
      count <= count + {2'b00, wr && !full} - {2'b00, rd && rd_valid};
    end
  end

endmodule

// ===== hdl/mfd_back.sv =====
// Back part: assembles fields from classified beats and holds finished
// records in a two-entry output buffer. Depends on mfd_pkg.
`timescale 1ns / 1ps
module mfd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           beat_valid,
  input  mfd_pkg::beat_t beat,
  output logic           beat_pop,
  output logic           empty,
  input  logic           pop,
  output logic [2:0]     msg_kind,
  output logic [31:0]    time_seconds,
  output logic [31:0]    time_fraction,
  output logic [63:0]    order_reference,
  output logic [7:0]     side_flag,
  output logic [31:0]    share_count,
  output logic [63:0]    symbol_bytes,
  output logic [31:0]    price_raw,
  output logic [31:0]    participant_id,
  output logic [63:0]    second_reference,
  output logic [7:0]     printable_flag
);

  localparam int RecW = 3 + 32*5 + 64*3 + 16;

  logic [63:0] f [6];
  logic        sym_ended;
  logic [31:0] seconds;
  logic [RecW-1:0] obuf [2];
  logic        wp, rp;
  logic [1:0]  count;
  logic        obuf_full, do_beat, emit;
  logic [7:0]  b;
  logic [63:0] fv [6];
  logic [RecW-1:0] rec;
  logic [3:0]  k;
  logic        flagged;

  assign obuf_full = (count == 2'd2);
  assign do_beat   = beat_valid && !obuf_full;
  assign beat_pop  = do_beat;
  assign k         = beat.kind;
  assign emit      = do_beat && beat.write && beat.last && k != mfd_pkg::KIND_T;

  always_comb begin
    b = beat.data;
    if (beat.sym && (sym_ended || mfd_pkg::is_ws(beat.data))) b = 8'h00;
    for (int i = 0; i < 6; i++) begin
      fv[i] = f[i];
      if (beat.slot == 3'(i)) fv[i] = {f[i][55:0], b};
    end
    flagged = (k == mfd_pkg::KIND_A || k == mfd_pkg::KIND_F || k == mfd_pkg::KIND_C);
    rec = {k[2:0], seconds,
           flagged ? fv[0][39:8] : fv[0][31:0],
           fv[1],
           (k <= mfd_pkg::KIND_F) ? fv[0][7:0] : 8'h00,
           fv[2][31:0], fv[3], fv[4][31:0],
           (k == mfd_pkg::KIND_F) ? fv[5][31:0] : 32'd0,
           (k == mfd_pkg::KIND_E || k == mfd_pkg::KIND_C || k == mfd_pkg::KIND_U) ?
             fv[5] : 64'd0,
           (k == mfd_pkg::KIND_C) ? fv[0][7:0] : 8'h00};
  end

  always_ff @(posedge clk) begin
    if (do_beat && beat.start) begin
      for (int i = 0; i < 6; i++) f[i] <= 64'd0;
    end else if (do_beat && beat.write) begin
      for (int i = 0; i < 6; i++) f[i] <= fv[i];
    end
    if (emit) obuf[wp] <= rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_ended <= 1'b0;
      seconds <= 32'd0;
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_beat && beat.start) sym_ended <= 1'b0;
      else if (do_beat && beat.sym && mfd_pkg::is_ws(beat.data)) sym_ended <= 1'b1;
      if (do_beat && beat.write && beat.last && k == mfd_pkg::KIND_T) seconds <= fv[0][31:0];
      if (emit) wp <= ~wp;
      if (pop && !empty) rp <= ~rp;
      count <= count + {1'b0, emit} - {1'b0, pop && !empty};
    end
  end

  assign empty = (count == 2'd0);
  assign {msg_kind, time_seconds, time_fraction, order_reference, side_flag, share_count,
          symbol_bytes, price_raw, participant_id, second_reference,
          printable_flag} = obuf[rp];

endmodule
